// ===== hw/rtl/ogba_pkg.sv =====
// shared types and constants for the outlier gated best-k average unit
package ogba_pkg;

    // default configuration of the list and sample path
    localparam int DEPTH_DEF        = 10;
    localparam int SAMPLE_WIDTH_DEF = 32;

    // fixed field widths
    localparam int IN_W        = 32;
    localparam int TOL_W       = 16;
    localparam int FRAC_W      = 16;
    localparam int AVG_OUT_W   = 32;
    localparam int CNT_OUT_W   = 4;
    localparam int OUT_TDATA_W = 40;

    // tolerance after reset, about 0.02 in q0.16
    localparam logic [TOL_W-1:0] TOL_RESET = 16'd1311;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_CMP,
        ST_INS,
        ST_DLOAD,
        ST_DIV,
        ST_OUT
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic mul;
        logic cmp;
        logic ins;
        logic div_load;
        logic div_step;
        logic out_load;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic reject;
        logic div_last;
    } t_sts;

endpackage

// ===== hw/rtl/ogba_ctrl.sv =====
// controller state machine sequencing one request through the datapath
module ogba_ctrl
    import ogba_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  logic i_out_ready,
    output logic o_out_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    // state and output valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_CMP;
            end
            ST_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = ST_INS;
            end
            ST_INS: begin
                if (i_sts.reject) begin
                    n_state = ST_OUT;
                end else begin
                    o_cmd.ins = 1'b1;
                    n_state   = ST_DLOAD;
                end
            end
            ST_DLOAD: begin
                o_cmd.div_load = 1'b1;
                n_state        = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // output holding register valid
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== hw/rtl/ogba_dp.sv =====
// datapath: band test, sorted list, running sum and bit-serial divider
module ogba_dp
    import ogba_pkg::*;
#(
    parameter int DEPTH        = DEPTH_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [TOL_W-1:0]       i_cfg_wr_data,
    input  logic [IN_W-1:0]        i_sample,
    input  t_cmd                   i_cmd,
    output t_sts                   o_sts,
    output logic                   o_rejected,
    output logic [AVG_OUT_W-1:0]   o_average,
    output logic [CNT_OUT_W-1:0]   o_stored_count
);

    localparam int EW    = (SAMPLE_WIDTH < IN_W) ? SAMPLE_WIDTH : IN_W;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int SUM_W = EW + CW;
    localparam int DC_W  = $clog2(SUM_W);
    localparam int PW    = EW + TOL_W;
    localparam int QW    = EW + FRAC_W;

    logic [TOL_W-1:0]     r_tol;
    logic [EW-1:0]        r_sample;
    logic [EW-1:0]        r_avg;
    logic                 r_seeded;
    logic [PW-1:0]        r_prod;
    logic                 r_reject;
    logic [EW-1:0]        r_ent [DEPTH];
    logic [EW-1:0]        n_ent [DEPTH];
    logic [DEPTH-1:0]     r_vld;
    logic [DEPTH-1:0]     n_vld;
    logic [SUM_W-1:0]     r_sum;
    logic [SUM_W-1:0]     n_sum;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        n_count;
    logic [CW-1:0]        r_rem;
    logic [CW-1:0]        n_rem;
    logic [SUM_W-1:0]     r_quo;
    logic [SUM_W-1:0]     n_quo;
    logic [DC_W-1:0]      r_dcnt;
    logic [AVG_OUT_W-1:0] r_out_avg;
    logic [CNT_OUT_W-1:0] r_out_cnt;
    logic                 r_out_rej;

    logic [QW:0]          cmp_lhs;
    logic [QW:0]          cmp_upper;
    logic [QW-1:0]        cmp_base;
    logic [QW-1:0]        cmp_lower;
    logic                 cmp_reject;
    logic [DEPTH-1:0]     ins_here;
    logic [DEPTH-1:0]     ins_prev;
    logic                 ins_any;
    logic                 list_full;
    logic [CW:0]          rem_sh;
    logic                 div_ge;
    logic                 div_last;
    logic [EW+AVG_OUT_W-1:0] avg_ext;
    logic [CW+CNT_OUT_W-1:0] cnt_ext;

    // tolerance band: sample*2^16 against avg*2^16 +/- avg*tol
    always_comb begin
        cmp_base   = {r_avg, {FRAC_W{1'b0}}};
        cmp_upper  = {1'b0, cmp_base} + {{(QW+1-PW){1'b0}}, r_prod};
        cmp_lower  = cmp_base - QW'(r_prod);
        cmp_lhs    = {1'b0, r_sample, {FRAC_W{1'b0}}};
        cmp_reject = (cmp_lhs > cmp_upper) || (cmp_lhs[QW-1:0] < cmp_lower);
    end

    // insert position as a thermometer, list is ascending with a valid prefix
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            ins_here[i] = !r_vld[i] || (r_sample < r_ent[i]);
        end
        ins_prev  = DEPTH'({ins_here, 1'b0});
        ins_any   = ins_here[DEPTH-1];
        list_full = r_vld[DEPTH-1];
    end

    // shifted list, valid prefix grows by one until full
    always_comb begin
        n_ent[0] = ins_here[0] ? r_sample : r_ent[0];
        for (int i = 1; i < DEPTH; i++) begin
            n_ent[i] = ins_here[i] ? (ins_prev[i] ? r_ent[i-1] : r_sample) : r_ent[i];
        end
        n_vld   = r_vld;
        n_sum   = r_sum;
        n_count = r_count;
        if (ins_any) begin
            n_vld = DEPTH'({r_vld, 1'b1});
            if (list_full) begin
                n_sum = r_sum + SUM_W'(r_sample) - SUM_W'(r_ent[DEPTH-1]);
            end else begin
                n_sum   = r_sum + SUM_W'(r_sample);
                n_count = r_count + CW'(1);
            end
        end
    end

    // one restoring divide step per cycle
    always_comb begin
        rem_sh   = {r_rem, r_quo[SUM_W-1]};
        div_ge   = rem_sh >= {1'b0, r_count};
        n_rem    = div_ge ? CW'(rem_sh - {1'b0, r_count}) : rem_sh[CW-1:0];
        n_quo    = {r_quo[SUM_W-2:0], div_ge};
        div_last = (r_dcnt == DC_W'(SUM_W - 1));
    end

    // control state: tolerance, seed, average, valid bits, sum, count and divide counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol    <= TOL_RESET;
            r_seeded <= 1'b0;
            r_avg    <= '0;
            r_vld    <= '0;
            r_sum    <= '0;
            r_count  <= '0;
            r_dcnt   <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_tol <= i_cfg_wr_data;
            end
            if (i_cmd.load && !r_seeded) begin
                r_avg    <= i_sample[EW-1:0];
                r_seeded <= 1'b1;
            end
            if (i_cmd.ins) begin
                r_vld   <= n_vld;
                r_sum   <= n_sum;
                r_count <= n_count;
            end
            if (i_cmd.div_load) begin
                r_dcnt <= '0;
            end else if (i_cmd.div_step) begin
                r_dcnt <= r_dcnt + DC_W'(1);
            end
            if (i_cmd.div_step && div_last) begin
                r_avg <= n_quo[EW-1:0];
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sample <= i_sample[EW-1:0];
        end
        if (i_cmd.mul) begin
            r_prod <= PW'(r_avg) * PW'(r_tol);
        end
        if (i_cmd.cmp) begin
            r_reject <= cmp_reject;
        end
        if (i_cmd.ins) begin
            r_ent <= n_ent;
        end
        if (i_cmd.div_load) begin
            r_rem <= '0;
            r_quo <= r_sum;
        end else if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
        if (i_cmd.out_load) begin
            r_out_rej <= r_reject;
            r_out_avg <= avg_ext[AVG_OUT_W-1:0];
            r_out_cnt <= cnt_ext[CNT_OUT_W-1:0];
        end
    end

    // result fields at their port widths, count wraps to four bits
    assign avg_ext = {{AVG_OUT_W{1'b0}}, r_avg};
    assign cnt_ext = {{CNT_OUT_W{1'b0}}, r_count};

    assign o_sts.reject   = r_reject;
    assign o_sts.div_last = div_last;
    assign o_rejected     = r_out_rej;
    assign o_average      = r_out_avg;
    assign o_stored_count = r_out_cnt;

endmodule

// ===== hw/rtl/outlier_gated_best_k_average_unit.sv =====
// top level of the outlier gated best-k average unit
// Each request carries one unsigned timing sample; the unit answers with one result
// holding the reject flag, the running average and the number of stored samples.
// The first sample after reset seeds the average. A sample outside
// avg*(1 +/- tolerance) is rejected and changes nothing; otherwise it enters an
// ascending list of the DEPTH smallest accepted samples and the average becomes
// floor(sum/count) of that list. One request is in work at a time. A rejected
// sample passes the states IDLE, MUL, CMP, INS and OUT; an accepted one also
// passes DLOAD and DIV, where the quotient has SUM_W = min(SAMPLE_WIDTH,32) +
// clog2(DEPTH+1) bits, 36 with the defaults, and the bit-serial divider forms the
// average one quotient bit per cycle. The result sits in an output register, so
// the next sample is taken while an earlier result still waits. The tolerance
// register may be written only while the unit is idle.
module outlier_gated_best_k_average_unit
    import ogba_pkg::*;
#(
    parameter int DEPTH        = DEPTH_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [TOL_W-1:0]       i_cfg_wr_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_W-1:0]        s_axis_tdata,   // [31:0] sample
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [31:0] average, [35:32] stored_count
    output logic [0:0]             m_axis_tuser    // [0] rejected
);

    t_cmd                 cmd;
    t_sts                 sts;
    logic                 rejected;
    logic [AVG_OUT_W-1:0] average;
    logic [CNT_OUT_W-1:0] stored_count;

    // controller
    ogba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // datapath
    ogba_dp #(
        .DEPTH        (DEPTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_sample       (s_axis_tdata),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_rejected     (rejected),
        .o_average      (average),
        .o_stored_count (stored_count)
    );

    // result packing
    assign m_axis_tdata = {{(OUT_TDATA_W-AVG_OUT_W-CNT_OUT_W){1'b0}}, stored_count, average};
    assign m_axis_tuser = rejected;

    // one request in work at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("new request taken while one is in work");

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
        else $error("output register loaded while a result is pending");

    // an accepted sample always leaves the list non-empty
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> (DEPTH > 15) || (stored_count != '0))
        else $error("accepted sample reported with an empty list");

endmodule

// ===== dv/testbench.sv =====
// testbench for the outlier gated best-k average unit, self-checking against a local predictor
`timescale 1ns / 100ps

module testbench;
    import ogba_pkg::*;

    localparam int LIST_DEPTH = DEPTH_DEF;

    // one expected result
    typedef struct packed {
        logic        rejected;
        logic [31:0] average;
        logic [3:0]  stored_count;
    } t_avg_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_wr_en = 1'b0;
    logic [TOL_W-1:0]       i_cfg_wr_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_W-1:0]        s_axis_tdata = '0;        // [31:0] sample
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;             // [31:0] average, [35:32] stored_count
    logic [0:0]             m_axis_tuser;             // [0] rejected

    // predictor state: best-k list, average and tolerance
    logic [31:0]      best_list [LIST_DEPTH];
    logic             best_valid [LIST_DEPTH];
    logic [31:0]      run_avg;
    logic             avg_seeded;
    logic [TOL_W-1:0] tol_q16;

    t_avg_result pending_results [$];
    int          fail_count = 0;
    int          rx_hold_req = 0;
    bit          tx_no_idle = 1'b0;
    bit          rx_no_idle = 1'b0;

    outlier_gated_best_k_average_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 8 ns clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // number of valid list entries
    function automatic int stored_entries();
        int n;
        n = 0;
        for (int i = 0; i < LIST_DEPTH; i++) begin
            if (best_valid[i]) n++;
        end
        return n;
    endfunction

    // gate, insert and re-average one accepted request
    function automatic t_avg_result predict_sample(input logic [31:0] s);
        logic [63:0] lhs;
        logic [63:0] upper;
        logic [63:0] lower;
        logic [63:0] sum;
        int          pos;
        int          cnt;
        t_avg_result r;
        if (!avg_seeded) begin
            run_avg = s;
            avg_seeded = 1'b1;
        end
        lhs = {32'd0, s} << 16;
        upper = 64'(run_avg) * (64'd65536 + 64'(tol_q16));
        lower = 64'(run_avg) * (64'd65536 - 64'(tol_q16));
        r.rejected = (lhs > upper) || (lhs < lower);
        if (!r.rejected) begin
            // first slot that is empty or holds a larger value
            pos = LIST_DEPTH;
            for (int i = 0; i < LIST_DEPTH; i++) begin
                if (pos == LIST_DEPTH && (!best_valid[i] || s < best_list[i])) pos = i;
            end
            if (pos < LIST_DEPTH) begin
                for (int j = LIST_DEPTH - 1; j > pos; j--) begin
                    best_list[j] = best_list[j-1];
                    best_valid[j] = best_valid[j-1];
                end
                best_list[pos] = s;
                best_valid[pos] = 1'b1;
            end
            sum = '0;
            cnt = 0;
            for (int i = 0; i < LIST_DEPTH; i++) begin
                if (best_valid[i]) begin
                    sum += 64'(best_list[i]);
                    cnt++;
                end
            end
            if (cnt != 0) run_avg = 32'(sum / 64'(cnt));
        end
        r.average = run_avg;
        r.stored_count = 4'(stored_entries());
        return r;
    endfunction

    // inclusive acceptance bounds around the current average
    function automatic logic [63:0] band_high();
        logic [63:0] hi;
        hi = (64'(run_avg) * (64'd65536 + 64'(tol_q16))) >> 16;
        if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
        return hi;
    endfunction

    function automatic logic [63:0] band_low();
        return (64'(run_avg) * (64'd65536 - 64'(tol_q16)) + 64'd65535) >> 16;
    endfunction

    // mostly in-band samples, with edges, near misses, repeats and noise
    function automatic logic [31:0] band_sample();
        logic [63:0] hi;
        logic [63:0] lo;
        int          pick;
        int          n;
        hi = band_high();
        lo = band_low();
        pick = $urandom_range(99);
        n = stored_entries();
        if (pick < 40) return $urandom_range(hi[31:0], run_avg);
        if (pick < 62) return $urandom_range(run_avg, lo[31:0]);
        if (pick < 72) return ($urandom_range(1) == 0) ? hi[31:0] : lo[31:0];
        if (pick < 80 && hi < 64'hFFFF_FFFF) return hi[31:0] + 32'd1;
        if (pick < 88 && lo > 0) return lo[31:0] - 32'd1;
        if (pick < 94 && n > 0) return best_list[$urandom_range(n - 1)];
        return $urandom;
    endfunction

    // idle length: mostly short, a few long
    function automatic int idle_gap();
        int pick;
        pick = $urandom_range(99);
        if (pick < 75) return $urandom_range(3, 1);
        if (pick < 95) return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    // offer one request and record its expected result once taken
    task automatic send_sample(input logic [31:0] s);
        int gap;
        gap = 0;
        if (!tx_no_idle && $urandom_range(2) == 0) gap = idle_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= $urandom;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= s;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_results.push_back(predict_sample(s));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // tolerance is only changed with the unit idle
    task automatic write_tolerance(input logic [TOL_W-1:0] v);
        wait_drained();
        repeat (8) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        tol_q16 = v;
    endtask

    // seeding at full scale, filling the list, equal values, drop and eviction
    task automatic test_seed_and_full_list();
        send_sample(32'hFFFF_FFFF);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'h0000_0000);
        send_sample(32'hFC00_0000);
        send_sample(32'hFD00_0000);
        send_sample(32'hFE00_0000);
        send_sample(32'hFB80_0000);
        send_sample(32'hFFFF_FFFE);
        send_sample(32'hFC00_0000);
        send_sample(32'hFE80_0000);
        send_sample(32'hFD80_0000);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'hFB00_0000);
        send_sample(32'(band_low() - 64'd1));
        send_sample(32'(band_low()));
    endtask

    // zero tolerance takes only the exact average, full tolerance a wide band
    task automatic test_tolerance_extremes();
        write_tolerance('0);
        send_sample(run_avg);
        send_sample(run_avg + 32'd1);
        send_sample(run_avg - 32'd1);
        write_tolerance('1);
        send_sample(32'(band_low() - 64'd1));
        send_sample(32'hFFFF_FFFF);
        send_sample(32'(band_low()));
    endtask

    task automatic test_random_traffic(input logic [TOL_W-1:0] tol, input int n,
                                       input bit no_idle);
        write_tolerance(tol);
        tx_no_idle = no_idle;
        rx_no_idle = no_idle;
        repeat (n) send_sample(band_sample());
        tx_no_idle = 1'b0;
        rx_no_idle = 1'b0;
    endtask

    // receiver holds off while requests keep coming, so the input stalls
    task automatic test_output_stall();
        write_tolerance(TOL_W'(3000));
        rx_hold_req = 400;
        tx_no_idle = 1'b1;
        repeat (100) send_sample(band_sample());
        tx_no_idle = 1'b0;
    endtask

    // result checking and receiver pacing
    initial begin : result_check
        t_avg_result exp_r;
        int          stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected result: tdata=%h tuser=%b", m_axis_tdata, m_axis_tuser);
                    fail_count++;
                end else begin
                    exp_r = pending_results.pop_front();
                    if (m_axis_tuser[0] !== exp_r.rejected) begin
                        $error("rejected: expected %0d, actual %0d",
                               exp_r.rejected, m_axis_tuser[0]);
                        fail_count++;
                    end
                    if (m_axis_tdata[31:0] !== exp_r.average) begin
                        $error("average: expected %0d, actual %0d",
                               exp_r.average, m_axis_tdata[31:0]);
                        fail_count++;
                    end
                    if (m_axis_tdata[35:32] !== exp_r.stored_count) begin
                        $error("stored_count: expected %0d, actual %0d",
                               exp_r.stored_count, m_axis_tdata[35:32]);
                        fail_count++;
                    end
                end
            end
            if (rx_hold_req > 0) begin
                stall_left = rx_hold_req;
                rx_hold_req = 0;
            end
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
                if (!rx_no_idle && $urandom_range(4) == 0) stall_left = idle_gap();
            end
        end
    end

    // reset, tests in turn, final verdict
    initial begin
        for (int i = 0; i < LIST_DEPTH; i++) begin
            best_list[i] = '0;
            best_valid[i] = 1'b0;
        end
        run_avg = '0;
        avg_seeded = 1'b0;
        tol_q16 = TOL_RESET;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_seed_and_full_list();
        test_tolerance_extremes();
        test_random_traffic(TOL_RESET, 300, 1'b0);
        test_random_traffic(TOL_W'($urandom), 250, 1'b1);
        test_output_stall();
        test_random_traffic(TOL_W'($urandom_range(8000, 200)), 300, 1'b0);
        test_random_traffic('0, 150, 1'b0);
        test_random_traffic(TOL_W'($urandom), 250, 1'b0);
        test_random_traffic('1, 200, 1'b0);

        wait_drained();
        repeat (60) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
